// ===== rtl/core/gdr_pkg.sv =====
// Shared types, constants and helpers of the grid DDA ray caster.
`default_nettype none
package gdr_pkg;
    localparam int MAP_SIDE     = 64;
    localparam int SCREEN_WIDTH = 640;
    localparam int MAP_AW       = $clog2(MAP_SIDE * MAP_SIDE);
    localparam int CAM_W        = 26;
    localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFF;

    // column * 2^15 / SCREEN_WIDTH as column * CAM_RECIP >> CAM_SHIFT, reciprocal rounded up
    localparam int     CAM_SHIFT = 21;
    localparam longint CAM_RECIP = ((longint'(1) << (15 + CAM_SHIFT)) + SCREEN_WIDTH - 1)
                                   / SCREEN_WIDTH;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CAST  = 1'b1;

    localparam logic [2:0] CFG_PLAYER_X = 3'd0;
    localparam logic [2:0] CFG_PLAYER_Y = 3'd1;
    localparam logic [2:0] CFG_DIR_X    = 3'd2;
    localparam logic [2:0] CFG_DIR_Y    = 3'd3;
    localparam logic [2:0] CFG_PLANE_X  = 3'd4;
    localparam logic [2:0] CFG_PLANE_Y  = 3'd5;
    localparam logic [2:0] CFG_COLS     = 3'd6;
    localparam logic [2:0] CFG_ROWS     = 3'd7;

    typedef struct packed {
        logic       action;
        logic [9:0] column;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic       cell_is_wall;
    } t_item;

    typedef struct packed {
        logic [15:0]        player_x;
        logic [15:0]        player_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] plane_x;
        logic signed [15:0] plane_y;
        logic [6:0]         cols;
        logic [6:0]         rows;
    } t_cfg;

    typedef struct packed {
        logic        start;
        logic [30:0] num;
        logic [15:0] den;
    } t_div_req;

    typedef struct packed {
        logic              valid;
        logic [9:0]        ray_column;
        logic              wall_hit;
        logic signed [7:0] final_x;
        logic signed [7:0] final_y;
        logic              hit_side;
        logic [31:0]       side_x;
        logic [31:0]       side_y;
        logic [31:0]       delta_x;
        logic [31:0]       delta_y;
    } t_result;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? DIST_MAX : s[31:0];
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/gdr_front.sv =====
// Front end: accepts items and queues them in order for the back end.
`default_nettype none
module gdr_front
    import gdr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_item i_item,
    output logic       o_busy,
    output logic       o_valid,
    output t_item      o_item,
    input  wire logic  i_pop
);
    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_busy  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign push    = i_start && !o_busy;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/gdr_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module gdr_div
    import gdr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output logic          o_done,
    output logic [30:0]   o_quo
);
    logic [30:0] r_num;
    logic [15:0] r_rem;
    logic [15:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [16:0] trial;
    logic        fits;

    assign trial  = {r_rem, r_num[30]};
    assign fits   = trial >= {1'b0, r_den};
    assign o_done = r_done;
    assign o_quo  = r_num;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_rem <= 16'd0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= fits ? 16'(trial - {1'b0, r_den}) : trial[15:0];
            r_num <= {r_num[29:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd31;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/gdr_back.sv =====
// Back end: map store, ray setup and the DDA walk sequencer.
`default_nettype none
module gdr_back
    import gdr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    output logic       o_pop,
    output t_result    o_res
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CAMW  = 4'd1;
    localparam logic [3:0] S_RAYX  = 4'd2;
    localparam logic [3:0] S_RAYX2 = 4'd3;
    localparam logic [3:0] S_RAYY  = 4'd4;
    localparam logic [3:0] S_RAYY2 = 4'd5;
    localparam logic [3:0] S_DX    = 4'd6;
    localparam logic [3:0] S_DXW   = 4'd7;
    localparam logic [3:0] S_DY    = 4'd8;
    localparam logic [3:0] S_DYW   = 4'd9;
    localparam logic [3:0] S_SIDEX = 4'd10;
    localparam logic [3:0] S_SIDEY = 4'd11;
    localparam logic [3:0] S_SIDE2 = 4'd12;
    localparam logic [3:0] S_STEP  = 4'd13;
    localparam logic [3:0] S_CHECK = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    logic                    wall_map [MAP_SIDE * MAP_SIDE];
    logic [3:0]              r_state;
    t_item                   r_item;
    logic signed [CAM_W-1:0] r_cam;
    logic signed [15:0]      r_rdx, r_rdy;
    logic signed [CAM_W+15:0] r_prod;
    logic [42:0]             r_spx, r_spy;
    logic [31:0]             r_ddx, r_ddy, r_sdx, r_sdy;
    logic signed [7:0]       r_mx, r_my;
    logic                    r_side, r_hit, r_rd;
    t_div_req                div_req;
    logic                    div_done;
    logic [30:0]             div_quo;

    logic [36:0]             cam_prod;
    logic signed [CAM_W+15:0] prod_sh;
    logic signed [CAM_W+15:0] ray_sum;
    logic signed [15:0]      ray_sat;
    logic [15:0]             mag;
    logic [10:0]             frac_x, frac_y;
    logic signed [9:0]       nx, ny, lim_c, lim_r;
    logic [31:0]             n_sdx, n_sdy;
    logic                    n_side, out_map;
    logic [15:0]             raddr;
    logic [15:0]             waddr;

    gdr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        div_req = '0;
        if (r_state == S_DX && r_rdx != 16'sd0) begin
            div_req.start = 1'b1;
            div_req.num   = 31'h4000_0000;
            div_req.den   = mag;
        end else if (r_state == S_DY && r_rdy != 16'sd0) begin
            div_req.start = 1'b1;
            div_req.num   = 31'h4000_0000;
            div_req.den   = mag;
        end
    end

    // camera offset numerator by reciprocal multiply
    assign cam_prod = 37'(r_item.column) * 37'(CAM_RECIP);

    // floor(plane * cam / 2^14) plus dir, saturated to 16 bits
    assign prod_sh = r_prod >>> 14;
    always_comb begin
        ray_sum = prod_sh + (CAM_W+16)'((r_state == S_RAYX2) ? i_cfg.dir_x : i_cfg.dir_y);
        if (ray_sum > (CAM_W+16)'(32767)) ray_sat = 16'sh7FFF;
        else if (ray_sum < -(CAM_W+16)'(32768)) ray_sat = -16'sh8000;
        else ray_sat = ray_sum[15:0];
    end

    always_comb begin
        if (r_state == S_DX) mag = r_rdx[15] ? 16'(-r_rdx) : r_rdx;
        else mag = r_rdy[15] ? 16'(-r_rdy) : r_rdy;
    end

    assign frac_x = r_rdx[15] ? {1'b0, i_cfg.player_x[9:0]} : 11'd1024 - {1'b0, i_cfg.player_x[9:0]};
    assign frac_y = r_rdy[15] ? {1'b0, i_cfg.player_y[9:0]} : 11'd1024 - {1'b0, i_cfg.player_y[9:0]};

    // one DDA step; ties go along y
    always_comb begin
        nx = 10'(r_mx);
        ny = 10'(r_my);
        n_sdx = r_sdx;
        n_sdy = r_sdy;
        if (r_sdx < r_sdy) begin
            n_sdx  = sat_add(r_sdx, r_ddx);
            nx     = 10'(r_mx) + (r_rdx[15] ? -10'sd1 : 10'sd1);
            n_side = 1'b0;
        end else begin
            n_sdy  = sat_add(r_sdy, r_ddy);
            ny     = 10'(r_my) + (r_rdy[15] ? -10'sd1 : 10'sd1);
            n_side = 1'b1;
        end
        lim_c = (10'(i_cfg.cols) > 10'(MAP_SIDE)) ? 10'(MAP_SIDE) : 10'(i_cfg.cols);
        lim_r = (10'(i_cfg.rows) > 10'(MAP_SIDE)) ? 10'(MAP_SIDE) : 10'(i_cfg.rows);
        out_map = nx < 10'sd0 || nx >= lim_c || ny < 10'sd0 || ny >= lim_r;
        raddr = 16'(ny) * 16'(MAP_SIDE) + 16'(nx);
        waddr = 16'(i_item.cell_y) * 16'(MAP_SIDE) + 16'(i_item.cell_x);
    end

    assign o_pop = (r_state == S_IDLE) && i_valid;

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.action == ACT_WRITE &&
            32'(i_item.cell_x) < 32'(MAP_SIDE) && 32'(i_item.cell_y) < 32'(MAP_SIDE)) begin
            wall_map[waddr[MAP_AW-1:0]] <= i_item.cell_is_wall;
        end
        if (r_state == S_STEP) r_rd <= wall_map[raddr[MAP_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE:  if (i_valid) r_item <= i_item;
            S_CAMW:  r_cam <= CAM_W'(cam_prod[36:CAM_SHIFT]) - CAM_W'(16384);
            S_RAYX:  r_prod <= (CAM_W+16)'(i_cfg.plane_x) * (CAM_W+16)'(r_cam);
            S_RAYX2: r_rdx <= ray_sat;
            S_RAYY:  r_prod <= (CAM_W+16)'(i_cfg.plane_y) * (CAM_W+16)'(r_cam);
            S_RAYY2: r_rdy <= ray_sat;
            S_DX:    if (r_rdx == 16'sd0) r_ddx <= DIST_MAX;
            S_DXW:   if (div_done) r_ddx <= 32'(div_quo);
            S_DY:    if (r_rdy == 16'sd0) r_ddy <= DIST_MAX;
            S_DYW:   if (div_done) r_ddy <= 32'(div_quo);
            S_SIDEX: begin
                r_spx <= 43'(frac_x) * 43'(r_ddx);
                r_mx  <= 8'(i_cfg.player_x[15:10]);
                r_my  <= 8'(i_cfg.player_y[15:10]);
            end
            S_SIDEY: r_spy <= 43'(frac_y) * 43'(r_ddy);
            S_SIDE2: begin
                r_sdx <= (r_spx[42:10] > 33'(DIST_MAX)) ? DIST_MAX : r_spx[41:10];
                r_sdy <= (r_spy[42:10] > 33'(DIST_MAX)) ? DIST_MAX : r_spy[41:10];
                r_hit <= 1'b0;
            end
            S_STEP: begin
                r_sdx  <= n_sdx;
                r_sdy  <= n_sdy;
                r_mx   <= nx[7:0];
                r_my   <= ny[7:0];
                r_side <= n_side;
            end
            S_CHECK: r_hit <= r_rd;
            S_DONE:  ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE:  if (o_pop && i_item.action == ACT_CAST) r_state <= S_CAMW;
                S_CAMW:  r_state <= S_RAYX;
                S_RAYX:  r_state <= S_RAYX2;
                S_RAYX2: r_state <= S_RAYY;
                S_RAYY:  r_state <= S_RAYY2;
                S_RAYY2: r_state <= S_DX;
                S_DX:    r_state <= (r_rdx == 16'sd0) ? S_DY : S_DXW;
                S_DXW:   if (div_done) r_state <= S_DY;
                S_DY:    r_state <= (r_rdy == 16'sd0) ? S_SIDEX : S_DYW;
                S_DYW:   if (div_done) r_state <= S_SIDEX;
                S_SIDEX: r_state <= S_SIDEY;
                S_SIDEY: r_state <= S_SIDE2;
                S_SIDE2: r_state <= S_STEP;
                S_STEP:  r_state <= out_map ? S_DONE : S_CHECK;
                S_CHECK: r_state <= r_rd ? S_DONE : S_STEP;
                S_DONE:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // hold result fields while the strobe is low; valid beat follows S_DONE
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            o_res.ray_column  <= r_item.column;
            o_res.wall_hit    <= r_hit;
            o_res.final_x     <= r_mx;
            o_res.final_y     <= r_my;
            o_res.hit_side    <= r_side;
            o_res.side_x      <= r_sdx;
            o_res.side_y      <= r_sdy;
            o_res.delta_x     <= r_ddx;
            o_res.delta_y     <= r_ddy;
        end
        if (!i_rst_n) o_res.valid <= 1'b0;
        else o_res.valid <= (r_state == S_DONE);
    end
endmodule
`default_nettype wire

// ===== rtl/core/grid_dda_raycaster.sv =====
// A write item updates the map when the back end takes it from the queue. A cast runs
// the camera offset, ray x and ray y, a serial divide for each nonzero ray component (a
// zero one gets DIST_MAX), start distances, then the DDA walk, each cell read in S_STEP
// and checked in S_CHECK. The back end handles one item at a time; both divides share one divider.
// Reset (synchronous, active low) clears control and loads register defaults; the map is
// not cleared. A two-entry queue feeds the back end; results are a one-cycle strobe.
`default_nettype none
module grid_dda_raycaster
    import gdr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic        i_action,
    input  wire logic [9:0]  i_column,
    input  wire logic [5:0]  i_cell_x,
    input  wire logic [5:0]  i_cell_y,
    input  wire logic        i_cell_is_wall,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    output logic             o_done,
    output logic [9:0]       o_ray_column,
    output logic             o_wall_hit,
    output logic signed [7:0] o_final_x,
    output logic signed [7:0] o_final_y,
    output logic             o_hit_side,
    output logic [31:0]      o_side_dist_x_out,
    output logic [31:0]      o_side_dist_y_out,
    output logic [31:0]      o_delta_x_out,
    output logic [31:0]      o_delta_y_out
);
    t_cfg    r_cfg;
    t_item   in_item, q_item;
    logic    q_valid, q_pop;
    t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.player_x <= 16'd32768;
            r_cfg.player_y <= 16'd32768;
            r_cfg.dir_x    <= 16'sd16384;
            r_cfg.dir_y    <= 16'sd0;
            r_cfg.plane_x  <= 16'sd0;
            r_cfg.plane_y  <= 16'sd10813;
            r_cfg.cols     <= 7'd64;
            r_cfg.rows     <= 7'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PLAYER_X: r_cfg.player_x <= i_cfg_data;
                CFG_PLAYER_Y: r_cfg.player_y <= i_cfg_data;
                CFG_DIR_X:    r_cfg.dir_x    <= i_cfg_data;
                CFG_DIR_Y:    r_cfg.dir_y    <= i_cfg_data;
                CFG_PLANE_X:  r_cfg.plane_x  <= i_cfg_data;
                CFG_PLANE_Y:  r_cfg.plane_y  <= i_cfg_data;
                CFG_COLS:     r_cfg.cols     <= i_cfg_data[6:0];
                CFG_ROWS:     r_cfg.rows     <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign in_item = '{action: i_action, column: i_column, cell_x: i_cell_x,
                       cell_y: i_cell_y, cell_is_wall: i_cell_is_wall};

    gdr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_item  (in_item),
        .o_busy  (o_busy),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    gdr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_pop   (q_pop),
        .o_res   (res)
    );

    assign o_done            = res.valid;
    assign o_ray_column      = res.ray_column;
    assign o_wall_hit        = res.wall_hit;
    assign o_final_x         = res.final_x;
    assign o_final_y         = res.final_y;
    assign o_hit_side        = res.hit_side;
    assign o_side_dist_x_out = res.side_x;
    assign o_side_dist_y_out = res.side_y;
    assign o_delta_x_out     = res.delta_x;
    assign o_delta_y_out     = res.delta_y;
endmodule
`default_nettype wire

// ===== rtl/core/gdr_checker.sv =====
// Port-level checker for the ray caster and its bind.
`default_nettype none
module gdr_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_busy,
    input wire logic             o_done,
    input wire logic             o_wall_hit,
    input wire logic signed [7:0] o_final_x,
    input wire logic signed [7:0] o_final_y
);
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_done && !o_busy)
        else $error("done or busy after reset");
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("back-to-back result beats");
    a_hit_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_wall_hit |-> o_final_x >= 8'sd0 && o_final_x < 8'sd64 &&
        o_final_y >= 8'sd0 && o_final_y < 8'sd64) else $error("hit cell off the map");
    a_final_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_final_x >= -8'sd1 && o_final_x <= 8'sd64 &&
        o_final_y >= -8'sd1 && o_final_y <= 8'sd64) else $error("final cell out of range");
endmodule

bind grid_dda_raycaster gdr_checker u_gdr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_busy     (o_busy),
    .o_done     (o_done),
    .o_wall_hit (o_wall_hit),
    .o_final_x  (o_final_x),
    .o_final_y  (o_final_y)
);
`default_nettype wire

// ===== sim/grid_dda_raycaster_tb.sv =====
// Self-checking testbench of the grid DDA ray caster: map loads, directed and random casts.
`default_nettype none
module grid_dda_raycaster_tb;
    import gdr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 32;
    localparam int END_WAIT    = 400;
    localparam int N_PHASES    = 8;
    localparam int ITEMS_PER_PHASE = 30;
    // walks stay inside this corner of the map, which is cleared first
    localparam int USED_SIDE   = 12;

    typedef struct {
        logic [9:0]  column;
        logic        wall_hit;
        logic [7:0]  final_x;
        logic [7:0]  final_y;
        logic        hit_side;
        logic [31:0] side_x;
        logic [31:0] side_y;
        logic [31:0] delta_x;
        logic [31:0] delta_y;
    } ray_hit_t;

    typedef struct {
        logic       action;
        logic [9:0] column;
        logic [5:0] cx;
        logic [5:0] cy;
        logic       wall;
        bit         typed;
        ray_hit_t   known;
    } dir_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        i_action = 1'b0;
    logic [9:0]  i_column = '0;
    logic [5:0]  i_cell_x = '0;
    logic [5:0]  i_cell_y = '0;
    logic        i_cell_is_wall = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;
    logic        o_busy, o_done, o_wall_hit, o_hit_side;
    logic [9:0]  o_ray_column;
    logic signed [7:0] o_final_x, o_final_y;
    logic [31:0] o_side_dist_x_out, o_side_dist_y_out, o_delta_x_out, o_delta_y_out;

    grid_dda_raycaster u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_action(i_action), .i_column(i_column), .i_cell_x(i_cell_x),
        .i_cell_y(i_cell_y), .i_cell_is_wall(i_cell_is_wall),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_done(o_done), .o_ray_column(o_ray_column), .o_wall_hit(o_wall_hit),
        .o_final_x(o_final_x), .o_final_y(o_final_y), .o_hit_side(o_hit_side),
        .o_side_dist_x_out(o_side_dist_x_out), .o_side_dist_y_out(o_side_dist_y_out),
        .o_delta_x_out(o_delta_x_out), .o_delta_y_out(o_delta_y_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the block state
    logic        wall_bits [MAP_SIDE*MAP_SIDE];
    logic [15:0] cfg_regs [8];
    ray_hit_t    pending_rays [$];
    dir_row_t    dir_rows [$];
    int          mismatches = 0;
    int          casts_sent = 0;
    int          writes_sent = 0;
    int          rays_checked = 0;
    int          walls_seen = 0;
    longint      cycle_count = 0;

    function automatic longint floor_q14(longint v);
        if (v >= 0) return v / 16384;
        return -((-v + 16383) / 16384);
    endfunction

    function automatic int ray_dir(logic [15:0] dir, logic [15:0] plane, longint cam);
        longint r;
        r = longint'($signed(dir)) + floor_q14(longint'($signed(plane)) * cam);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return int'(r);
    endfunction

    function automatic logic [31:0] inv_dist(int d);
        longint m;
        m = (d < 0) ? -longint'(d) : longint'(d);
        if (m == 0) return DIST_MAX;
        return 32'((longint'(1) << 30) / m);
    endfunction

    function automatic logic [31:0] start_dist(longint frac, logic [31:0] delta);
        longint p;
        p = (frac * longint'(delta)) >>> 10;
        return (p > longint'(DIST_MAX)) ? DIST_MAX : 32'(p);
    endfunction

    function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? DIST_MAX : s[31:0];
    endfunction

    function automatic ray_hit_t predict_ray(logic [9:0] column);
        ray_hit_t r;
        longint cam;
        int rdx, rdy, mx, my, sx, sy, cols, rows;
        logic [31:0] ddx, ddy, sdx, sdy;
        longint fx, fy;
        bit hit, side;
        hit = 0;
        side = 0;
        cam = (longint'(column) * 32768) / SCREEN_WIDTH - 16384;
        rdx = ray_dir(cfg_regs[CFG_DIR_X], cfg_regs[CFG_PLANE_X], cam);
        rdy = ray_dir(cfg_regs[CFG_DIR_Y], cfg_regs[CFG_PLANE_Y], cam);
        ddx = inv_dist(rdx);
        ddy = inv_dist(rdy);
        mx = int'(cfg_regs[CFG_PLAYER_X] >> 10);
        my = int'(cfg_regs[CFG_PLAYER_Y] >> 10);
        fx = longint'(cfg_regs[CFG_PLAYER_X] & 16'h3FF);
        fy = longint'(cfg_regs[CFG_PLAYER_Y] & 16'h3FF);
        sx = (rdx < 0) ? -1 : 1;
        sy = (rdy < 0) ? -1 : 1;
        sdx = start_dist((rdx < 0) ? fx : 1024 - fx, ddx);
        sdy = start_dist((rdy < 0) ? fy : 1024 - fy, ddy);
        cols = (cfg_regs[CFG_COLS][6:0] > MAP_SIDE) ? MAP_SIDE : int'(cfg_regs[CFG_COLS][6:0]);
        rows = (cfg_regs[CFG_ROWS][6:0] > MAP_SIDE) ? MAP_SIDE : int'(cfg_regs[CFG_ROWS][6:0]);
        forever begin
            // ties go along y
            if (sdx < sdy) begin
                sdx = add_sat(sdx, ddx);
                mx += sx;
                side = 0;
            end else begin
                sdy = add_sat(sdy, ddy);
                my += sy;
                side = 1;
            end
            if (mx < 0 || mx >= cols || my < 0 || my >= rows) break;
            if (wall_bits[my*MAP_SIDE + mx]) begin
                hit = 1;
                break;
            end
        end
        r.column = column;
        r.wall_hit = hit;
        r.final_x = 8'(mx);
        r.final_y = 8'(my);
        r.hit_side = side;
        r.side_x = sdx;
        r.side_y = sdy;
        r.delta_x = ddx;
        r.delta_y = ddy;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH col %0d %s: got 0x%0h expected 0x%0h",
                 o_ray_column, field, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d rays pending", cycle_count,
                     pending_rays.size());
            $display("** grid_dda_raycaster: FAILED **");
            $finish;
        end
    end

    // check each result beat against the oldest pending ray
    always @(posedge i_clk) begin
        ray_hit_t e;
        if (i_rst_n && o_done) begin
            if (pending_rays.size() == 0) begin
                report_mismatch("unexpected beat", 32'd1, 32'd0);
            end else begin
                e = pending_rays.pop_front();
                rays_checked++;
                if (o_wall_hit) walls_seen++;
                if (o_ray_column !== e.column) report_mismatch("ray_column", o_ray_column, e.column);
                if (o_wall_hit !== e.wall_hit) report_mismatch("wall_hit", o_wall_hit, e.wall_hit);
                if (o_final_x !== e.final_x) report_mismatch("final_x", o_final_x, e.final_x);
                if (o_final_y !== e.final_y) report_mismatch("final_y", o_final_y, e.final_y);
                if (o_hit_side !== e.hit_side) report_mismatch("hit_side", o_hit_side, e.hit_side);
                if (o_side_dist_x_out !== e.side_x)
                    report_mismatch("x side distance", o_side_dist_x_out, e.side_x);
                if (o_side_dist_y_out !== e.side_y)
                    report_mismatch("y side distance", o_side_dist_y_out, e.side_y);
                if (o_delta_x_out !== e.delta_x) report_mismatch("delta_x", o_delta_x_out, e.delta_x);
                if (o_delta_y_out !== e.delta_y) report_mismatch("delta_y", o_delta_y_out, e.delta_y);
            end
        end
    end

    // present one item after a gap; returns at the edge that accepted it
    task automatic send_item(logic act, logic [9:0] col, logic [5:0] cx, logic [5:0] cy,
                             logic wall, int gap, bit typed, ray_hit_t known);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_action <= act;
        i_column <= col;
        i_cell_x <= cx;
        i_cell_y <= cy;
        i_cell_is_wall <= wall;
        do @(posedge i_clk); while (o_busy);
        if (act == ACT_WRITE) begin
            wall_bits[cy*MAP_SIDE + cx] = wall;
            writes_sent++;
        end else begin
            pending_rays.push_back(typed ? known : predict_ray(col));
            casts_sent++;
        end
    endtask

    task automatic drain_idle();
        i_start <= 1'b0;
        while (pending_rays.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic load_registers(logic [15:0] vals [8]);
        for (int k = 0; k < 8; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= 3'(k);
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            cfg_regs[k] = (k >= CFG_COLS) ? (vals[k] & 16'h7F) : vals[k];
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_signed();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic add_row(logic act, logic [9:0] col, logic [5:0] cx, logic [5:0] cy,
                           logic wall);
        dir_row_t r;
        r.action = act;
        r.column = col;
        r.cx = cx;
        r.cy = cy;
        r.wall = wall;
        r.typed = 0;
        r.known = '{default: '0};
        dir_rows.push_back(r);
    endtask

    initial begin
        ray_hit_t none;
        dir_row_t row;
        logic [15:0] vals [8];
        int gap_max;
        none = '{default: '0};
        cfg_regs = '{16'd32768, 16'd32768, 16'd16384, 16'd0, 16'd0, 16'd10813, 16'd64, 16'd64};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset view from the middle of the small used map
        vals = '{16'd6656, 16'd6656, 16'd16384, 16'd0, 16'd0, 16'd10813,
                 16'(USED_SIDE), 16'(USED_SIDE)};
        load_registers(vals);

        // clear every cell a walk can reach so none reads an unwritten one
        for (int c = 0; c < USED_SIDE*USED_SIDE; c++)
            send_item(ACT_WRITE, '0, 6'(c % USED_SIDE), 6'(c / USED_SIDE), 1'b0, 0, 0, none);

        // centered ray on an empty map: runs east off the map
        row.action = ACT_CAST;
        row.column = 10'd320;
        row.cx = '0;
        row.cy = '0;
        row.wall = 1'b0;
        row.typed = 1;
        row.known = '{10'd320, 1'b0, 8'd12, 8'd6, 1'b0, 32'h0006_8000, 32'h7FFF_FFFF,
                      32'h0001_0000, DIST_MAX};
        dir_rows.push_back(row);
        add_row(ACT_WRITE, '0, 6'd9, 6'd6, 1'b1);
        add_row(ACT_CAST, 10'd320, '0, '0, 1'b0);
        add_row(ACT_CAST, 10'd0, '0, '0, 1'b0);
        add_row(ACT_CAST, 10'd639, '0, '0, 1'b0);
        add_row(ACT_CAST, 10'd1023, '0, '0, 1'b0);
        add_row(ACT_CAST, 10'd512, '0, '0, 1'b0);
        add_row(ACT_WRITE, '0, 6'd11, 6'd11, 1'b1);
        add_row(ACT_WRITE, '0, 6'd0, 6'd0, 1'b1);
        add_row(ACT_WRITE, '0, 6'd8, 6'd3, 1'b1);
        add_row(ACT_WRITE, '0, 6'd8, 6'd9, 1'b1);
        add_row(ACT_CAST, 10'd100, '0, '0, 1'b0);
        add_row(ACT_CAST, 10'd540, '0, '0, 1'b0);
        add_row(ACT_WRITE, '0, 6'd9, 6'd6, 1'b0);
        add_row(ACT_CAST, 10'd320, '0, '0, 1'b0);
        add_row(ACT_CAST, 10'd319, '0, '0, 1'b0);
        add_row(ACT_CAST, 10'd321, '0, '0, 1'b0);
        foreach (dir_rows[i])
            send_item(dir_rows[i].action, dir_rows[i].column, dir_rows[i].cx, dir_rows[i].cy,
                      dir_rows[i].wall, $urandom_range(0, 11), dir_rows[i].typed,
                      dir_rows[i].known);

        for (int p = 0; p < N_PHASES; p++) begin
            drain_idle();
            for (int k = 0; k < 8; k++) vals[k] = 16'($urandom());
            if (p == 0) begin
                vals = '{16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                         16'd1, 16'd1};
            end else if (p == 1) begin
                vals = '{16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                         16'd127, 16'd127};
            end else if (p == 2) begin
                // zero direction and empty map size
                vals = '{16'($urandom()), 16'($urandom()), 16'h0000, 16'h0000, 16'h0000,
                         16'h0000, 16'd0, 16'd64};
            end else begin
                vals[CFG_DIR_X] = pick_signed();
                vals[CFG_DIR_Y] = pick_signed();
                vals[CFG_PLANE_X] = pick_signed();
                vals[CFG_PLANE_Y] = pick_signed();
                vals[CFG_COLS] = 16'($urandom_range(0, USED_SIDE));
                vals[CFG_ROWS] = 16'($urandom_range(0, USED_SIDE));
                // keep the viewer inside the used map most of the time
                if ($urandom_range(0, 3) != 0) begin
                    vals[CFG_PLAYER_X] = 16'($urandom_range(0, USED_SIDE*1024 - 1));
                    vals[CFG_PLAYER_Y] = 16'($urandom_range(0, USED_SIDE*1024 - 1));
                end
            end
            load_registers(vals);
            gap_max = (p % 3 == 1) ? 0 : 11;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 9) < 3)
                    send_item(ACT_WRITE, 10'($urandom()), 6'($urandom()), 6'($urandom()),
                              ($urandom_range(0, 9) < 3), $urandom_range(0, gap_max), 0, none);
                else
                    send_item(ACT_CAST, ($urandom_range(0, 9) == 0) ? 10'($urandom())
                              : 10'($urandom_range(0, 639)), 6'($urandom()), 6'($urandom()),
                              1'($urandom()), $urandom_range(0, gap_max), 0, none);
            end
        end

        i_start <= 1'b0;
        while (pending_rays.size() != 0) @(posedge i_clk);
        repeat (END_WAIT) @(posedge i_clk);
        $display("covered %0d map writes and %0d casts over %0d register settings",
                 writes_sent, casts_sent, N_PHASES + 1);
        $display("%0d rays checked, %0d ended on a wall, %0d mismatches",
                 rays_checked, walls_seen, mismatches);
        if (mismatches == 0 && pending_rays.size() == 0)
            $display("** grid_dda_raycaster: PASSED **");
        else
            $display("** grid_dda_raycaster: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
